// File: rtl/aup_pkg.sv
// ----------------------------------------------------------------------------
// aup_pkg
// Shared widths and the alpha reciprocal ROM for the unpremultiply pipeline.
// ----------------------------------------------------------------------------
package aup_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned PixelW  = 4 * ChanW;
  localparam int unsigned RecipW  = 24;
  localparam int unsigned ProdW   = ChanW + RecipW;
  localparam int unsigned RomSize = 1 << ChanW;

  localparam logic [ChanW-1:0]  ChanMax   = 8'hFF;
  localparam logic [ProdW-1:0]  RoundHalf = 32'd32768;
  localparam logic [RecipW-1:0] RecipNum  = 24'(255 * 65536);

  typedef logic [ChanW-1:0]  chan_t;
  typedef logic [RecipW-1:0] recip_t;
  typedef logic [ProdW-1:0]  prod_t;
  typedef recip_t            recip_rom_t [RomSize];

  // Rounded 8.16 reciprocal floor((255*65536 + a/2) / a) by shift-subtract.
  // Used only to build the ROM at elaboration.
  function automatic recip_t recip_calc(input chan_t a);
    recip_t           num;
    recip_t           quo;
    logic [ChanW:0]   rem;
    num = RecipNum + recip_t'(a >> 1);
    quo = '0;
    rem = '0;
    if (a != '0) begin
      for (int i = RecipW - 1; i >= 0; i--) begin
        rem = {rem[ChanW-1:0], num[i]};
        if (rem >= {1'b0, a}) begin
          rem    = rem - {1'b0, a};
          quo[i] = 1'b1;
        end
      end
    end
    return quo;
  endfunction

  function automatic recip_rom_t build_recip_rom();
    recip_rom_t rom;
    for (int i = 0; i < RomSize; i++) begin
      rom[i] = recip_calc(chan_t'(i));
    end
    return rom;
  endfunction

  localparam recip_rom_t RecipRom = build_recip_rom();

endpackage

// File: rtl/alpha_unpremultiply_pixel.sv
// ----------------------------------------------------------------------------
// alpha_unpremultiply_pixel
// Premultiplied ARGB to straight-alpha ARGB, one pixel per clock.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_premult_pixel and raise start; the pixel transfers at any edge
//   where start is high and busy is low. busy is always low, so a new pixel
//   may transfer in every cycle.
//   Each result appears on out_red/out_green/out_blue/out_alpha for exactly
//   one cycle with out_valid high, after passing the stage 1, stage 2 and output registers.
//   Throughput is one pixel per clock, set by the three-stage pipeline:
//   reciprocal ROM lookup, three 8x24 multiplies, then round and saturate.
//   The receiver cannot stall, so nothing is ever held back.
//   Reset clears the valid bits of all stages; pixels in flight are dropped
//   and no result is strobed until a new pixel transfers.
// ----------------------------------------------------------------------------
module alpha_unpremultiply_pixel
  import aup_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [PixelW-1:0] in_premult_pixel,
  output logic              out_valid,
  output logic [ChanW-1:0]  out_red,
  output logic [ChanW-1:0]  out_green,
  output logic [ChanW-1:0]  out_blue,
  output logic [ChanW-1:0]  out_alpha
);

  typedef struct packed {
    logic opaque;
    logic clear;
  } sel_t;

  logic  xfer;
  chan_t in_a, in_r, in_g, in_b;

  // stage 1: split, classify, reciprocal lookup
  logic   s1_valid_r;
  sel_t   s1_sel_r;
  recip_t s1_inv_r;
  chan_t  s1_a_r, s1_r_r, s1_g_r, s1_b_r;

  // stage 2: products
  logic   s2_valid_r;
  sel_t   s2_sel_r;
  chan_t  s2_a_r, s2_r_r, s2_g_r, s2_b_r;
  prod_t  s2_pr_r, s2_pg_r, s2_pb_r;

  // stage 3: output registers
  logic   out_valid_r;
  chan_t  out_red_r, out_green_r, out_blue_r, out_alpha_r;
  chan_t  red_nxt, green_nxt, blue_nxt;

  assign busy = 1'b0;
  assign xfer = start && !busy;

  assign in_a = in_premult_pixel[4*ChanW-1:3*ChanW];
  assign in_r = in_premult_pixel[3*ChanW-1:2*ChanW];
  assign in_g = in_premult_pixel[2*ChanW-1:ChanW];
  assign in_b = in_premult_pixel[ChanW-1:0];

  function automatic chan_t round_sat(input prod_t p);
    prod_t sum;
    sum = p + RoundHalf;
    if (sum[ProdW-1:16+ChanW] != '0) begin
      return ChanMax;
    end
    return sum[16+ChanW-1:16];
  endfunction

  always_comb begin
    if (s2_sel_r.opaque) begin
      red_nxt   = s2_r_r;
      green_nxt = s2_g_r;
      blue_nxt  = s2_b_r;
    end else if (s2_sel_r.clear) begin
      red_nxt   = '0;
      green_nxt = '0;
      blue_nxt  = '0;
    end else begin
      red_nxt   = round_sat(s2_pr_r);
      green_nxt = round_sat(s2_pg_r);
      blue_nxt  = round_sat(s2_pb_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= xfer;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_sel_r.opaque <= (in_a == ChanMax);
    s1_sel_r.clear  <= (in_a == '0);
    s1_inv_r        <= RecipRom[in_a];
    s1_a_r          <= in_a;
    s1_r_r          <= in_r;
    s1_g_r          <= in_g;
    s1_b_r          <= in_b;

    s2_sel_r <= s1_sel_r;
    s2_a_r   <= s1_a_r;
    s2_r_r   <= s1_r_r;
    s2_g_r   <= s1_g_r;
    s2_b_r   <= s1_b_r;
    s2_pr_r  <= prod_t'(s1_r_r) * prod_t'(s1_inv_r);
    s2_pg_r  <= prod_t'(s1_g_r) * prod_t'(s1_inv_r);
    s2_pb_r  <= prod_t'(s1_b_r) * prod_t'(s1_inv_r);

    out_red_r   <= red_nxt;
    out_green_r <= green_nxt;
    out_blue_r  <= blue_nxt;
    out_alpha_r <= s2_a_r;
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;
  assign out_alpha = out_alpha_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("transfer did not produce a result after three cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result strobed without a matching input transfer");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_alpha == '0) |->
      (out_red == '0 && out_green == '0 && out_blue == '0))
    else $error("transparent pixel kept nonzero color");

  a_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_alpha == ChanMax) |->
      (out_red == $past(in_premult_pixel[3*ChanW-1:2*ChanW], 3) &&
       out_blue == $past(in_premult_pixel[ChanW-1:0], 3)))
    else $error("opaque pixel color changed");
`endif

endmodule
